### design/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and constants of the periodic task dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int TASK_SLOTS_DEF = 8;
  localparam int MAX_RESULTS = 8;
  localparam int PERIOD_W = 16;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_CREATE  = 3'd1;
  localparam logic [2:0] OP_SUSPEND = 3'd2;
  localparam logic [2:0] OP_RESUME  = 3'd3;
  localparam logic [2:0] OP_DELETE  = 3'd4;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic                present;
    logic                resumed;
  } slot_rec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_WAIT,
    S_NEXT,
    S_FLUSH
  } state_t;

endpackage

### design/ptd_cell.sv
// ----------------------------------------------------------------------------
// ptd_cell
// One task slot record in the ring; takes its neighbor's record on a shift.
// ----------------------------------------------------------------------------
module ptd_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  ptd_pkg::slot_rec_t nb,
  input  logic              we,
  input  ptd_pkg::slot_rec_t wd,
  output ptd_pkg::slot_rec_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (we) begin
      q <= wd;
    end else if (shift) begin
      q <= nb;
    end
  end

endmodule

### design/ptd_mod.sv
// ----------------------------------------------------------------------------
// ptd_mod
// Restoring bit-serial remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ptd_mod (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ptd_pkg::PERIOD_W-1:0] dividend,
  input  logic [ptd_pkg::PERIOD_W-1:0] divisor,
  output logic                         busy,
  output logic                         rem_zero
);

  localparam int W = ptd_pkg::PERIOD_W;

  logic [W:0]             rem;
  logic [W-1:0]           sh;
  logic [$clog2(W+1)-1:0] cnt;
  logic [W:0]             trial;

  assign trial = {rem[W-1:0], sh[W-1]};
  assign busy = (cnt != '0);
  assign rem_zero = (rem == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= ($clog2(W+1))'(W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      sh  <= dividend;
    end else if (busy) begin
      sh <= {sh[W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= trial - {1'b0, divisor};
      end else begin
        rem <= trial;
      end
    end
  end

endmodule

### design/periodic_task_dispatcher_core.sv
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_core
// Task slot ring with a shared remainder unit that dispatches due slots.
// ----------------------------------------------------------------------------
// A table operation acts as it is accepted; its result shows the cycle after.
// A tick walks the slot ring one slot per step: an idle slot passes EVAL and NEXT,
// a live one also waits in WAIT on the serial remainder unit, and a stalled
// output can hold NEXT and FLUSH.
// One transaction is in work at a time. Reset clears the counter and all slots.
module periodic_task_dispatcher_core #(
  parameter int TASK_SLOTS = ptd_pkg::TASK_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] opcode,
  input  logic [7:0] task_slot,
  input  logic [15:0] period,
  input  logic       has_routine,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] run_slot,
  output logic       dispatch_valid,
  output logic       slot_error,
  output logic       last
);

  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int NW = $clog2(ptd_pkg::MAX_RESULTS + 1);

  ptd_pkg::state_t    state, state_next;
  ptd_pkg::slot_rec_t cell_q [TASK_SLOTS];
  ptd_pkg::slot_rec_t wd;
  logic [TASK_SLOTS-1:0] we;
  logic               shift;

  logic [15:0]   tick_count;
  logic [SW-1:0] step, step_next;
  logic [NW-1:0] nres, nres_next;
  logic          due, due_next;
  logic          pend_valid, pend_valid_next;
  logic [2:0]    pend_slot, pend_slot_next;

  logic       div_start, div_busy, div_zero;
  logic       out_free, accept, in_range;
  logic       emit, emit_dv, emit_err, emit_last;
  logic [2:0] emit_slot;
  ptd_pkg::slot_rec_t sel;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ptd_pkg::S_IDLE) && out_free;
  assign accept = in_valid && in_ready;
  assign in_range = ({1'b0, task_slot} < 9'(TASK_SLOTS));
  assign sel = cell_q[task_slot[SW-1:0]];

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    ptd_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .shift(shift),
      .nb   (cell_q[(i + 1) % TASK_SLOTS]),
      .we   (we[i]),
      .wd   (wd),
      .q    (cell_q[i])
    );
  end

  ptd_mod u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(tick_count),
    .divisor (cell_q[0].period),
    .busy    (div_busy),
    .rem_zero(div_zero)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ptd_pkg::S_IDLE;
      tick_count <= '0;
      step       <= '0;
      nres       <= '0;
      due        <= 1'b0;
      pend_valid <= 1'b0;
      pend_slot  <= '0;
    end else begin
      state      <= state_next;
      step       <= step_next;
      nres       <= nres_next;
      due        <= due_next;
      pend_valid <= pend_valid_next;
      pend_slot  <= pend_slot_next;
      if (accept && opcode == ptd_pkg::OP_TICK) begin
        tick_count <= tick_count + 1'b1;
      end
    end
  end

  always_comb begin
    state_next      = state;
    step_next       = step;
    nres_next       = nres;
    due_next        = due;
    pend_valid_next = pend_valid;
    pend_slot_next  = pend_slot;
    div_start       = 1'b0;
    shift           = 1'b0;
    we              = '0;
    wd              = sel;
    emit            = 1'b0;
    emit_slot       = '0;
    emit_dv         = 1'b0;
    emit_err        = 1'b0;
    emit_last       = 1'b1;
    unique case (state)
      ptd_pkg::S_IDLE: begin
        if (accept) begin
          if (opcode == ptd_pkg::OP_TICK) begin
            step_next       = '0;
            nres_next       = '0;
            pend_valid_next = 1'b0;
            state_next      = ptd_pkg::S_EVAL;
          end else begin
            emit = 1'b1;
            priority if (opcode == ptd_pkg::OP_CREATE) begin
              wd.period  = period;
              wd.present = 1'b1;
              wd.resumed = 1'b1;
              emit_err   = !(in_range && has_routine);
            end else if (opcode == ptd_pkg::OP_SUSPEND) begin
              wd.resumed = 1'b0;
              emit_err   = !in_range;
            end else if (opcode == ptd_pkg::OP_RESUME) begin
              wd.resumed = 1'b1;
              emit_err   = !in_range;
            end else if (opcode == ptd_pkg::OP_DELETE) begin
              wd.present = 1'b0;
              emit_err   = !in_range;
            end else begin
              emit_err = 1'b1;
            end
            if (!emit_err) begin
              we[task_slot[SW-1:0]] = 1'b1;
            end
          end
        end
      end
      ptd_pkg::S_EVAL: begin
        if (cell_q[0].present && cell_q[0].resumed && cell_q[0].period != '0 &&
            nres < NW'(ptd_pkg::MAX_RESULTS)) begin
          div_start  = 1'b1;
          state_next = ptd_pkg::S_WAIT;
        end else begin
          due_next   = 1'b0;
          state_next = ptd_pkg::S_NEXT;
        end
      end
      ptd_pkg::S_WAIT: begin
        if (!div_busy) begin
          due_next   = div_zero;
          state_next = ptd_pkg::S_NEXT;
        end
      end
      ptd_pkg::S_NEXT: begin
        if (!(due && pend_valid && !out_free)) begin
          if (due) begin
            if (pend_valid) begin
              emit      = 1'b1;
              emit_slot = pend_slot;
              emit_dv   = 1'b1;
              emit_last = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_slot_next  = 3'(step);
            nres_next       = nres + 1'b1;
          end
          shift     = 1'b1;
          step_next = step + 1'b1;
          if (step == SW'(TASK_SLOTS - 1)) begin
            state_next = ptd_pkg::S_FLUSH;
          end else begin
            state_next = ptd_pkg::S_EVAL;
          end
        end
      end
      ptd_pkg::S_FLUSH: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_slot  = pend_valid ? pend_slot : 3'd0;
          emit_dv    = pend_valid;
          state_next = ptd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ptd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      run_slot       <= emit_slot;
      dispatch_valid <= emit_dv;
      slot_error     <= emit_err;
      last           <= emit_last;
    end
  end

endmodule

### design/ptd_checker.sv
// ----------------------------------------------------------------------------
// ptd_checker
// Port-level checks of the periodic task dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module ptd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] opcode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] run_slot,
  input logic       dispatch_valid,
  input logic       slot_error,
  input logic       last
);

  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(run_slot) && $stable(last))
    else $error("stalled result changed");

  a_table_op: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode != ptd_pkg::OP_TICK |=>
      out_valid && last && !dispatch_valid)
    else $error("table transaction gave no single result");

  a_no_err_dispatch: assert property (@(posedge clk) disable iff (rst)
    out_valid && dispatch_valid |-> !slot_error)
    else $error("dispatch flagged as error");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !dispatch_valid |-> last)
    else $error("non-dispatch result not final");

endmodule

bind periodic_task_dispatcher_core ptd_checker u_ptd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .opcode        (opcode),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .run_slot      (run_slot),
  .dispatch_valid(dispatch_valid),
  .slot_error    (slot_error),
  .last          (last)
);

### sim/ptd_checker.sv
// ----------------------------------------------------------------------------
// ptd_tb_checker
// Watches both channels of the periodic task dispatcher, predicts the
// dispatch results of every accepted transaction and compares them in order.
// ----------------------------------------------------------------------------
module ptd_tb_checker #(
  parameter int TASK_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [7:0]  task_slot,
  input  logic [15:0] period,
  input  logic        has_routine,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  run_slot,
  input  logic        dispatch_valid,
  input  logic        slot_error,
  input  logic        last,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [2:0] run_slot;
    logic       dispatch_valid;
    logic       slot_error;
    logic       last;
  } dispatch_t;

  dispatch_t   expected_q[$];
  logic [15:0] ticks;
  logic [15:0] periods [TASK_SLOTS];
  logic        present [TASK_SLOTS];
  logic        resumed [TASK_SLOTS];

  assign pending = expected_q.size();

  task automatic predict_dispatch(input logic [2:0] op, input logic [7:0] slot,
                                  input logic [15:0] per, input logic routine);
    dispatch_t r;
    int        n;
    logic      ok;
    n = 0;
    ok = slot < TASK_SLOTS;
    r = '0;
    r.last = 1'b1;
    if (op == ptd_pkg::OP_TICK) begin
      ticks = ticks + 16'd1;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        if (n < ptd_pkg::MAX_RESULTS && present[i] && resumed[i] && periods[i] != 0 &&
            ticks % periods[i] == 0) begin
          if (n > 0) expected_q[$].last = 1'b0;
          r.run_slot = i[2:0];
          r.dispatch_valid = 1'b1;
          expected_q.push_back(r);
          n++;
        end
      end
      if (n == 0) expected_q.push_back(r);
    end else begin
      if (op == ptd_pkg::OP_CREATE) begin
        if (ok && routine) begin
          periods[slot] = per;
          present[slot] = 1'b1;
          resumed[slot] = 1'b1;
        end else begin
          r.slot_error = 1'b1;
        end
      end else if (op == ptd_pkg::OP_SUSPEND || op == ptd_pkg::OP_RESUME ||
                   op == ptd_pkg::OP_DELETE) begin
        if (!ok) r.slot_error = 1'b1;
        else if (op == ptd_pkg::OP_SUSPEND) resumed[slot] = 1'b0;
        else if (op == ptd_pkg::OP_RESUME) resumed[slot] = 1'b1;
        else present[slot] = 1'b0;
      end else begin
        r.slot_error = 1'b1;
      end
      expected_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    dispatch_t got;
    dispatch_t exp_r;
    if (rst) begin
      ticks = '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        periods[i] = '0;
        present[i] = 1'b0;
        resumed[i] = 1'b0;
      end
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {run_slot, dispatch_valid, slot_error, last};
        if (expected_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %p", got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("mismatch: expected %p, got %p", exp_r, got);
          end
        end
      end
      if (in_valid && in_ready) predict_dispatch(opcode, task_slot, period, has_routine);
    end
  end
endmodule

### sim/tb_periodic_task_dispatcher_core.sv
// ----------------------------------------------------------------------------
// tb_periodic_task_dispatcher_core
// Drives directed and random table operations and ticks into the dispatcher
// with random gaps and output stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_periodic_task_dispatcher_core;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  opcode = ptd_pkg::OP_TICK;
  logic [7:0]  task_slot = '0;
  logic [15:0] period = '0;
  logic        has_routine = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  run_slot;
  logic        dispatch_valid;
  logic        slot_error;
  logic        last;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  logic        hold_off = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  periodic_task_dispatcher_core i_dut (.*);

  ptd_tb_checker i_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) < 70);
  end

  task automatic send(input logic [2:0] op, input logic [7:0] slot,
                      input logic [15:0] per, input logic routine, input logic gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    task_slot <= slot;
    period <= per;
    has_routine <= routine;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random();
    int r;
    logic [7:0] s;
    r = $urandom_range(0, 99);
    s = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    if (r < 55) send(ptd_pkg::OP_TICK, 8'($urandom), 16'($urandom), 1'($urandom), 1'b1);
    else if (r < 75)
      send(ptd_pkg::OP_CREATE, s, ($urandom_range(0, 9) == 0) ? 16'($urandom) :
           16'($urandom_range(0, 6)), ($urandom_range(0, 9) != 0), 1'b1);
    else if (r < 84) send(ptd_pkg::OP_SUSPEND, s, 16'($urandom), 1'($urandom), 1'b1);
    else if (r < 93) send(ptd_pkg::OP_RESUME, s, 16'($urandom), 1'($urandom), 1'b1);
    else if (r < 98) send(ptd_pkg::OP_DELETE, s, 16'($urandom), 1'($urandom), 1'b1);
    else send(3'($urandom_range(5, 7)), 8'($urandom), 16'($urandom), 1'($urandom), 1'b1);
  endtask

  initial begin
    int waited;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send(ptd_pkg::OP_TICK, 8'd0, 16'd0, 1'b0, 1'b0);
    send(ptd_pkg::OP_CREATE, 8'd0, 16'd1, 1'b1, 1'b0);
    send(ptd_pkg::OP_CREATE, 8'd7, 16'hFFFF, 1'b1, 1'b0);
    send(ptd_pkg::OP_CREATE, 8'd3, 16'd0, 1'b1, 1'b0);
    send(ptd_pkg::OP_CREATE, 8'd2, 16'd2, 1'b0, 1'b0);
    send(ptd_pkg::OP_CREATE, 8'd8, 16'd2, 1'b1, 1'b0);
    send(ptd_pkg::OP_CREATE, 8'd255, 16'd2, 1'b1, 1'b0);
    send(ptd_pkg::OP_TICK, 8'd0, 16'd0, 1'b0, 1'b0);
    send(ptd_pkg::OP_SUSPEND, 8'd0, 16'd0, 1'b0, 1'b0);
    send(ptd_pkg::OP_TICK, 8'd0, 16'd0, 1'b0, 1'b0);
    send(ptd_pkg::OP_RESUME, 8'd0, 16'd0, 1'b0, 1'b0);
    send(ptd_pkg::OP_SUSPEND, 8'd5, 16'd0, 1'b0, 1'b0);
    send(ptd_pkg::OP_RESUME, 8'd5, 16'd0, 1'b0, 1'b0);
    send(ptd_pkg::OP_SUSPEND, 8'd200, 16'd0, 1'b0, 1'b0);
    send(ptd_pkg::OP_RESUME, 8'd9, 16'd0, 1'b0, 1'b0);
    send(ptd_pkg::OP_DELETE, 8'd128, 16'd0, 1'b0, 1'b0);
    for (int i = 1; i < 7; i++) send(ptd_pkg::OP_CREATE, 8'(i), 16'd1, 1'b1, 1'b0);
    send(ptd_pkg::OP_TICK, 8'd0, 16'd0, 1'b0, 1'b0);
    send(ptd_pkg::OP_DELETE, 8'd1, 16'd0, 1'b0, 1'b0);
    send(3'd5, 8'd0, 16'd0, 1'b0, 1'b0);
    send(3'd7, 8'hFF, 16'hFFFF, 1'b1, 1'b0);
    fork
      begin
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
      end
      for (int i = 0; i < 30; i++) send_random();
    join
    for (int i = 0; i < 374; i++) send_random();
    in_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
